[hw/rtl/pae_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pae_pkg;

    // Pool size and derived widths
    localparam int POOL_SLOTS = 512;
    localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int LINK_W     = $clog2(POOL_SLOTS + 1);

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LINK_W-1:0] link_t;

    // Null link: one past the last slot
    localparam link_t LINK_NULL = LINK_W'(POOL_SLOTS);

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Entry of the age-list memory: active mark and link to the next newer slot
    typedef struct packed {
        logic  active;
        link_t newer;
    } prev_entry_t;

    // Command word
    typedef struct packed {
        logic       command;
        logic [8:0] slot_to_free;
    } cmd_word_t;

    // Response word
    typedef struct packed {
        logic [8:0] granted_slot;
        logic       evicted;
        logic [8:0] evicted_slot;
        logic       error;
        logic [9:0] active_count;
    } rsp_word_t;

    function automatic logic link_is_slot(link_t l);
        return l != LINK_NULL;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/pae_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pae_cmd_if;
    import pae_pkg::*;

    logic      valid;
    logic      ready;
    cmd_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/pae_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pae_rsp_if;
    import pae_pkg::*;

    logic      valid;
    logic      ready;
    rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/pool_allocator_evict_oldest_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Word fields
// --------+-----+-------------------------------------------------------------
// cmd     | in  | command, slot_to_free
// rsp     | out | granted_slot, evicted, evicted_slot, error, active_count
//
// One command at a time. Allocate steps through S_ALLOC_RD and S_ALLOC_UPD, free
// through S_REL_UPD and S_REL_PUSH; both load the response word in S_DONE. An
// evicting allocate runs the free steps first; a refused free goes to S_DONE early.
// The steps are dependent read-modify-writes on the two link memories.
// Reset needs no clearing pass: a fill count stands in for the initial free list.
// A new command is taken while a word waits; its own word holds in S_DONE until
// the response register is free.

module pool_allocator_evict_oldest_top
    import pae_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    pae_cmd_if.sink    cmd,
    pae_rsp_if.source  rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REL_UPD,
        S_REL_PUSH,
        S_ALLOC_RD,
        S_ALLOC_UPD,
        S_DONE
    } state_t;

    state_t      state_reg;
    slot_t       cur_reg;
    logic        evict_reg;
    link_t       free_head_reg;
    link_t       newest_reg;
    link_t       oldest_reg;
    link_t       live_count_reg;
    link_t       fill_reg;
    logic [8:0]  res_granted_reg;
    logic [8:0]  res_evslot_reg;
    logic        res_error_reg;
    logic        rsp_valid_reg;
    rsp_word_t   rsp_data_reg;

    // Link memories
    link_t       next_mem [POOL_SLOTS];
    prev_entry_t prev_mem [POOL_SLOTS];
    link_t       next_rd_reg;
    prev_entry_t prev_rd_reg;

    slot_t       rd_addr;
    logic        next_we;
    slot_t       next_wa;
    link_t       next_wd;
    logic        prev_we;
    slot_t       prev_wa;
    prev_entry_t prev_wd;

    logic        cmd_fire;
    logic        rsp_free;
    logic        cur_touched;
    link_t       next_val;
    link_t       rel_newer;
    logic        rel_ok;
    logic        tgt_in_pool;

    assign cmd.ready  = (state_reg == S_IDLE);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.data   = rsp_data_reg;
    assign rsp_free   = !rsp_valid_reg || rsp.ready;

    assign tgt_in_pool = (32'(cmd.data.slot_to_free) < POOL_SLOTS);

    // Entries at or above the fill count were never written: reset contents
    assign cur_touched = (LINK_W'(cur_reg) < fill_reg);
    assign next_val    = cur_touched ? next_rd_reg : (LINK_W'(cur_reg) + LINK_W'(1));
    assign rel_newer   = prev_rd_reg.newer;
    assign rel_ok      = cur_touched && prev_rd_reg.active;

    // Read address
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            if (cmd.data.command == CMD_FREE)
                rd_addr = SLOT_W'(cmd.data.slot_to_free);
            else if (!link_is_slot(free_head_reg))
                rd_addr = oldest_reg[SLOT_W-1:0];
            else
                rd_addr = free_head_reg[SLOT_W-1:0];
        end
        else
        begin
            rd_addr = cur_reg;
        end
    end

    // Write ports
    always_comb
    begin
        next_we = 1'b0;
        next_wa = cur_reg;
        next_wd = free_head_reg;
        prev_we = 1'b0;
        prev_wa = cur_reg;
        prev_wd = '{active: 1'b0, newer: LINK_NULL};
        unique case (state_reg)
            S_REL_UPD:
            begin
                // bypass the slot being unlinked
                next_we = rel_ok && link_is_slot(rel_newer);
                next_wa = rel_newer[SLOT_W-1:0];
                next_wd = next_val;
                prev_we = rel_ok && link_is_slot(next_val);
                prev_wa = next_val[SLOT_W-1:0];
                prev_wd = '{active: 1'b1, newer: rel_newer};
            end
            S_REL_PUSH:
            begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            S_ALLOC_RD:
            begin
                prev_we = link_is_slot(newest_reg);
                prev_wa = newest_reg[SLOT_W-1:0];
                prev_wd = '{active: 1'b1, newer: LINK_W'(cur_reg)};
            end
            S_ALLOC_UPD:
            begin
                next_we = 1'b1;
                next_wd = newest_reg;
                prev_we = 1'b1;
                prev_wd = '{active: 1'b1, newer: LINK_NULL};
            end
            default:
            begin
            end
        endcase
    end

    // Next-link memory
    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_wa] <= next_wd;
        next_rd_reg <= next_mem[rd_addr];
    end

    // Age-list memory
    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        prev_rd_reg <= prev_mem[rd_addr];
    end

    // Sequencer and list pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cur_reg         <= '0;
            evict_reg       <= 1'b0;
            free_head_reg   <= '0;
            newest_reg      <= LINK_NULL;
            oldest_reg      <= LINK_NULL;
            live_count_reg  <= '0;
            fill_reg        <= '0;
            res_granted_reg <= '0;
            res_evslot_reg  <= '0;
            res_error_reg   <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_data_reg    <= '0;
        end
        else
        begin
            // word taken; S_DONE reloads the register itself
            if (rsp_valid_reg && rsp.ready && (state_reg != S_DONE))
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        cur_reg         <= rd_addr;
                        res_granted_reg <= '0;
                        res_evslot_reg  <= '0;
                        res_error_reg   <= 1'b0;
                        evict_reg       <= 1'b0;
                        if (cmd.data.command == CMD_FREE)
                        begin
                            if (tgt_in_pool)
                                state_reg <= S_REL_UPD;
                            else
                            begin
                                res_error_reg <= 1'b1;
                                state_reg     <= S_DONE;
                            end
                        end
                        else if (!link_is_slot(free_head_reg))
                        begin
                            // pool exhausted: reclaim the oldest slot first
                            evict_reg      <= 1'b1;
                            res_evslot_reg <= 9'(oldest_reg[SLOT_W-1:0]);
                            state_reg      <= S_REL_UPD;
                        end
                        else
                        begin
                            state_reg <= S_ALLOC_RD;
                        end
                    end
                end
                S_REL_UPD:
                begin
                    if (rel_ok)
                    begin
                        if (!link_is_slot(rel_newer))
                            newest_reg <= next_val;
                        if (!link_is_slot(next_val))
                            oldest_reg <= rel_newer;
                        state_reg <= S_REL_PUSH;
                    end
                    else
                    begin
                        res_error_reg <= 1'b1;
                        state_reg     <= S_DONE;
                    end
                end
                S_REL_PUSH:
                begin
                    free_head_reg  <= LINK_W'(cur_reg);
                    live_count_reg <= live_count_reg - LINK_W'(1);
                    state_reg      <= evict_reg ? S_ALLOC_RD : S_DONE;
                end
                S_ALLOC_RD:
                begin
                    state_reg <= S_ALLOC_UPD;
                end
                S_ALLOC_UPD:
                begin
                    free_head_reg   <= next_val;
                    if (!link_is_slot(newest_reg))
                        oldest_reg <= LINK_W'(cur_reg);
                    newest_reg      <= LINK_W'(cur_reg);
                    live_count_reg  <= live_count_reg + LINK_W'(1);
                    if (!cur_touched)
                        fill_reg <= LINK_W'(cur_reg) + LINK_W'(1);
                    res_granted_reg <= 9'(cur_reg);
                    state_reg       <= S_DONE;
                end
                S_DONE:
                begin
                    // hand the word over once the response register is free
                    if (rsp_free)
                    begin
                        rsp_valid_reg             <= 1'b1;
                        rsp_data_reg.granted_slot <= res_granted_reg;
                        rsp_data_reg.evicted      <= evict_reg;
                        rsp_data_reg.evicted_slot <= res_evslot_reg;
                        rsp_data_reg.error        <= res_error_reg;
                        rsp_data_reg.active_count <= 10'(live_count_reg);
                        state_reg                 <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // An empty free list means every slot is active
    a_empty_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !link_is_slot(free_head_reg) |-> (live_count_reg == LINK_W'(POOL_SLOTS)))
        else $error("free list empty while slots remain inactive");

    // Between commands the age list is empty exactly when nothing is active
    a_list_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!link_is_slot(newest_reg) == (live_count_reg == '0)))
        else $error("age list and live count disagree");

    // The fill count never passes the pool size, nor the live count the fill count
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(fill_reg) <= POOL_SLOTS) && (32'(live_count_reg) <= 32'(fill_reg)))
        else $error("fill count or live count out of range");

    // A rejected free grants and evicts nothing
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.error) |->
            (!rsp_data_reg.evicted && (rsp_data_reg.granted_slot == '0)))
        else $error("error word carries a grant or eviction");
`endif

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import pae_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 10;
    localparam int DIR_ROWS     = 17;
    localparam int SEGMENTS     = 4;

    typedef enum int { SEG_FILL, SEG_MIXED, SEG_DRAIN } seg_mode_t;

    // One row of the directed table; want is only used when typed is set
    typedef struct {
        logic       command;
        logic [8:0] slot;
        bit         typed;
        rsp_word_t  want;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pae_cmd_if cmd_if ();
    pae_rsp_if rsp_if ();

    pool_allocator_evict_oldest_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always #6 clk = ~clk;

    // Shadow of the pool: free stack, age list and live marks
    link_t       older_link [POOL_SLOTS];
    link_t       newer_link [POOL_SLOTS];
    bit          slot_live  [POOL_SLOTS];
    link_t       free_top;
    link_t       newest_at;
    link_t       oldest_at;
    int unsigned live_total;

    rsp_word_t   pending_rsp [$];
    int unsigned fail_count   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned stall_left   = 0;
    int unsigned alloc_count  = 0;
    int unsigned free_count   = 0;
    int unsigned evict_count  = 0;
    int unsigned reject_count = 0;
    bit          quiet        = 1'b0;

    function automatic stim_row_t make_row(logic c, logic [8:0] s, bit typed, int g = 0,
                                           int ev = 0, int es = 0, int er = 0, int n = 0);
        stim_row_t row_v;
        row_v.command = c;
        row_v.slot    = s;
        row_v.typed   = typed;
        row_v.want    = '{granted_slot: 9'(g), evicted: 1'(ev), evicted_slot: 9'(es),
                          error: 1'(er), active_count: 10'(n)};
        return row_v;
    endfunction

    // Unlink an active slot from the age list and push it on the free stack
    function automatic void pool_release(link_t s);
        link_t nw;
        link_t od;
        nw = newer_link[s];
        od = older_link[s];
        if (nw != LINK_NULL)
            older_link[nw] = od;
        else
            newest_at = od;
        if (od != LINK_NULL)
            newer_link[od] = nw;
        else
            oldest_at = nw;
        older_link[s] = free_top;
        free_top      = s;
        slot_live[s]  = 1'b0;
        if (live_total > 0)
            live_total--;
    endfunction

    // Apply one command word to the shadow pool and return the response it calls for
    function automatic rsp_word_t pool_apply(cmd_word_t w);
        rsp_word_t r;
        link_t     s;
        r = '0;
        if (w.command == CMD_FREE)
        begin
            free_count++;
            if (slot_live[w.slot_to_free])
            begin
                pool_release(link_t'(w.slot_to_free));
            end
            else
            begin
                r.error = 1'b1;
                reject_count++;
            end
        end
        else
        begin
            alloc_count++;
            // empty free stack: reclaim the oldest slot first
            if (free_top == LINK_NULL && oldest_at != LINK_NULL)
            begin
                r.evicted      = 1'b1;
                r.evicted_slot = oldest_at[SLOT_W-1:0];
                evict_count++;
                pool_release(oldest_at);
            end
            s = free_top;
            if (s != LINK_NULL)
            begin
                free_top      = older_link[s];
                older_link[s] = newest_at;
                newer_link[s] = LINK_NULL;
                if (newest_at != LINK_NULL)
                    newer_link[newest_at] = s;
                else
                    oldest_at = s;
                newest_at      = s;
                slot_live[s]   = 1'b1;
                live_total++;
                r.granted_slot = s[SLOT_W-1:0];
            end
        end
        r.active_count = 10'(live_total);
        return r;
    endfunction

    // Pick a live slot: the oldest, the newest, or one somewhere in between
    function automatic logic [8:0] pick_live_slot();
        int unsigned k;
        int unsigned start;
        k = $urandom_range(0, 3);
        if (k == 0)
            return oldest_at[8:0];
        if (k == 1)
            return newest_at[8:0];
        start = $urandom_range(0, POOL_SLOTS - 1);
        for (int i = 0; i < POOL_SLOTS; i++)
            if (slot_live[(start + i) % POOL_SLOTS])
                return 9'((start + i) % POOL_SLOTS);
        return 9'(start);
    endfunction

    // Gap length: none while quiet, else mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one command word; called and left at a falling edge
    task automatic send_word(input cmd_word_t w, input bit typed, input rsp_word_t want);
        int unsigned gap;
        rsp_word_t   predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= w;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        predicted = pool_apply(w);
        pending_rsp.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Hold off the sender until every response word is back
    task automatic wait_all_back();
        cmd_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // Response side back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    // Response checker
    always @(posedge clk)
    begin
        rsp_word_t due;
        if (rsp_if.valid && rsp_if.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response word with no command outstanding");
                fail_count++;
            end
            else
            begin
                due = pending_rsp.pop_front();
                if (rsp_if.data.granted_slot !== due.granted_slot)
                begin
                    $error("granted_slot: expected %0d, got %0d",
                           due.granted_slot, rsp_if.data.granted_slot);
                    fail_count++;
                end
                if (rsp_if.data.evicted !== due.evicted)
                begin
                    $error("evicted: expected %0d, got %0d", due.evicted, rsp_if.data.evicted);
                    fail_count++;
                end
                if (rsp_if.data.evicted_slot !== due.evicted_slot)
                begin
                    $error("evicted_slot: expected %0d, got %0d",
                           due.evicted_slot, rsp_if.data.evicted_slot);
                    fail_count++;
                end
                if (rsp_if.data.error !== due.error)
                begin
                    $error("error: expected %0d, got %0d", due.error, rsp_if.data.error);
                    fail_count++;
                end
                if (rsp_if.data.active_count !== due.active_count)
                begin
                    $error("active_count: expected %0d, got %0d",
                           due.active_count, rsp_if.data.active_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving either way
    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t   rows [DIR_ROWS];
        seg_mode_t   seg_plan [SEGMENTS];
        int unsigned seg_len [SEGMENTS];
        cmd_word_t   w;
        int unsigned r;

        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        rsp_if.ready = 1'b0;

        // Pool after reset: all free, stack runs 0 upwards
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            older_link[i] = link_t'(i + 1);
            newer_link[i] = LINK_NULL;
            slot_live[i]  = 1'b0;
        end
        free_top   = '0;
        newest_at  = LINK_NULL;
        oldest_at  = LINK_NULL;
        live_total = 0;

        // command, slot, typed, granted, evicted, evicted slot, error, count
        rows = '{
            make_row(CMD_FREE,  9'd0,     1, 0, 0, 0, 1, 0), // free on empty pool
            make_row(CMD_FREE,  9'd511,   1, 0, 0, 0, 1, 0),
            make_row(CMD_ALLOC, 9'd511,   1, 0, 0, 0, 0, 1), // slot field ignored
            make_row(CMD_ALLOC, 9'h155,   1, 1, 0, 0, 0, 2),
            make_row(CMD_ALLOC, 9'h0AA,   1, 2, 0, 0, 0, 3),
            make_row(CMD_FREE,  9'd1,     1, 0, 0, 0, 0, 2), // middle of age list
            make_row(CMD_FREE,  9'd1,     1, 0, 0, 0, 1, 2), // double free
            make_row(CMD_ALLOC, 9'd0,     1, 1, 0, 0, 0, 3), // last freed comes back
            make_row(CMD_FREE,  9'd0,     1, 0, 0, 0, 0, 2), // oldest
            make_row(CMD_FREE,  9'd1,     1, 0, 0, 0, 0, 1), // newest
            make_row(CMD_FREE,  9'd2,     1, 0, 0, 0, 0, 0), // only one left
            make_row(CMD_ALLOC, 9'd0,     0),
            make_row(CMD_ALLOC, 9'h1FF,   0),
            make_row(CMD_FREE,  9'h100,   1, 0, 0, 0, 1, 2),
            make_row(CMD_FREE,  9'h0FF,   1, 0, 0, 0, 1, 2),
            make_row(CMD_FREE,  9'd2,     0),
            make_row(CMD_ALLOC, 9'd0,     0)
        };

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            w.command      = rows[i].command;
            w.slot_to_free = rows[i].slot;
            send_word(w, rows[i].typed, rows[i].want);
        end
        wait_all_back();

        // Random segments: fill past full to force eviction, then churn, drain and fill again
        seg_plan = '{SEG_FILL, SEG_MIXED, SEG_DRAIN, SEG_FILL};
        seg_len  = '{700, 250, 600, 400};
        for (int p = 0; p < SEGMENTS; p++)
        begin
            quiet = (seg_plan[p] == SEG_MIXED);
            for (int n = 0; n < seg_len[p]; n++)
            begin
                r              = $urandom_range(0, 99);
                w.command      = CMD_FREE;
                w.slot_to_free = 9'($urandom_range(0, POOL_SLOTS - 1));
                case (seg_plan[p])
                    SEG_FILL:
                    begin
                        if (r < 92)
                            w.command = CMD_ALLOC;
                        else if (r < 97 && live_total > 0)
                            w.slot_to_free = pick_live_slot();
                    end
                    SEG_DRAIN:
                    begin
                        if (r < 85 && live_total > 0)
                            w.slot_to_free = pick_live_slot();
                        else if (r >= 93)
                            w.command = CMD_ALLOC;
                    end
                    default:
                    begin
                        if (r < 50)
                            w.command = CMD_ALLOC;
                        else if (r < 85 && live_total > 0)
                            w.slot_to_free = pick_live_slot();
                    end
                endcase
                send_word(w, 1'b0, '0);
            end
            wait_all_back();
        end
        quiet = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d allocates, %0d of them evicting, and %0d frees, %0d refused.",
                 alloc_count, evict_count, free_count, reject_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[pool_allocator_evict_oldest_top.f]
hw/rtl/pae_pkg.sv
hw/rtl/pae_cmd_if.sv
hw/rtl/pae_rsp_if.sv
hw/rtl/pool_allocator_evict_oldest_top.sv
test/tb_top.sv
